### rtl/dual_threshold_thermal_alarm_core_defines.svh
// Assertion macros for the thermal alarm core.
`ifndef DUAL_THRESHOLD_THERMAL_ALARM_CORE_DEFINES_SVH
`define DUAL_THRESHOLD_THERMAL_ALARM_CORE_DEFINES_SVH

// Checked only outside reset.
`define DTTA_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define DTTA_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/dtta_pkg.sv
`default_nettype none
package dtta_pkg;

   localparam int TEMP_BITS     = 12;
   localparam int TIME_BITS     = 32;
   localparam int NOW_BITS      = 32;
   localparam int DWELL_BITS    = 32;
   localparam int CMP_BITS      = (TIME_BITS > DWELL_BITS) ? TIME_BITS : DWELL_BITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [TEMP_BITS-1:0]  PRE_THR_RESET   = TEMP_BITS'(400);
   localparam logic [TEMP_BITS-1:0]  ALM_THR_RESET   = TEMP_BITS'(560);
   localparam logic [DWELL_BITS-1:0] PRE_DWELL_RESET = DWELL_BITS'(5000);
   localparam logic [DWELL_BITS-1:0] ALM_DWELL_RESET = DWELL_BITS'(5000);

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_PRE    = 2'd1,
      MODE_ALARM  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_PRE    = 3'd1,
      EV_ALARM  = 3'd2,
      EV_NORMAL = 3'd3,
      EV_BUTTON = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      REG_PRE_THR   = 2'd0,
      REG_ALM_THR   = 2'd1,
      REG_PRE_DWELL = 2'd2,
      REG_ALM_DWELL = 2'd3
   } reg_idx_type;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_BUTTON = 1'b1;

   typedef struct packed {
      logic                        kind;
      logic signed [TEMP_BITS-1:0] temperature;
      logic [NOW_BITS-1:0]         now_ms;
   } req_type;

   typedef struct packed {
      mode_type                    mode;
      event_type                   event_res;
      logic                        alarm_light;
      logic                        close_door;
      logic                        reset_enabled;
      logic signed [TEMP_BITS-1:0] temperature_report;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/dual_threshold_thermal_alarm_core.sv
// Dual-threshold thermal alarm core.
// Items on the req_ channel are temperature samples (kind 0) with a
// millisecond time stamp, or reset-button presses (kind 1). Each item
// gives exactly one item on the rsp_ channel: mode, event code, lamp,
// door-close pulse, button-armed flag and the echoed sample.
// Thresholds and dwell times sit on the APB-style port; the user writes
// them only while the core is idle, which the core does not enforce.
// Reads return the stored values. An accepted item sits in the input
// register, and the mode and timer update loads the result register
// once the output is free, where rsp_valid rises. Throughput is one
// item per cycle unless stalled; the single mode/timer update step bounds it.
// Reset clears both stages, puts the mode in normal, stops both dwell
// timers and loads the register defaults.
// When rsp_stall is high the result register holds; the input register
// still takes one more item, then req_stall rises until the result moves.
`default_nettype none
module dual_threshold_thermal_alarm_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dtta_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dtta_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dtta_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dtta_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dtta_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import dtta_pkg::*;

   logic [TEMP_BITS-1:0]  pre_thr_ff, alm_thr_ff;
   logic [DWELL_BITS-1:0] pre_dwell_ff, alm_dwell_ff;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   mode_type              mode_ff, mode_in;
   logic                  pre_run_ff, pre_run_in, alm_run_ff, alm_run_in;
   logic [TIME_BITS-1:0]  pre_start_ff, pre_start_in, alm_start_ff, alm_start_in;

   logic                  out_free, advance, req_take, csr_write;
   reg_idx_type           csr_idx;

   logic                  is_sample, pre_above, alm_above;
   logic                  pre_run_tr, alm_run_tr, pre_hit, alm_hit;
   logic [TIME_BITS-1:0]  now_t, pre_start_tr, alm_start_tr, pre_elapsed, alm_elapsed;
   event_type             ev;
   logic                  door;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration port
   assign pready    = 1'b1;
   assign csr_idx   = reg_idx_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_idx)
         REG_PRE_THR:   prdata = CSR_DATA_BITS'(pre_thr_ff);
         REG_ALM_THR:   prdata = CSR_DATA_BITS'(alm_thr_ff);
         REG_PRE_DWELL: prdata = CSR_DATA_BITS'(pre_dwell_ff);
         REG_ALM_DWELL: prdata = CSR_DATA_BITS'(alm_dwell_ff);
         default:       prdata = '0;
      endcase
   end

   // timer tracking
   assign is_sample = (in_item_ff.kind == KIND_SAMPLE);
   assign now_t     = TIME_BITS'(in_item_ff.now_ms);
   assign pre_above = in_item_ff.temperature >= $signed(pre_thr_ff);
   assign alm_above = in_item_ff.temperature >= $signed(alm_thr_ff);

   assign pre_run_tr   = pre_above;
   assign alm_run_tr   = alm_above;
   assign pre_start_tr = !pre_above ? '0 : (pre_run_ff ? pre_start_ff : now_t);
   assign alm_start_tr = !alm_above ? '0 : (alm_run_ff ? alm_start_ff : now_t);
   assign pre_elapsed  = now_t - pre_start_tr;
   assign alm_elapsed  = now_t - alm_start_tr;
   assign pre_hit = pre_run_tr && (CMP_BITS'(pre_elapsed) >= CMP_BITS'(pre_dwell_ff));
   assign alm_hit = alm_run_tr && (CMP_BITS'(alm_elapsed) >= CMP_BITS'(alm_dwell_ff));

   // next state
   always_comb begin
      mode_in      = mode_ff;
      pre_run_in   = pre_run_ff;
      pre_start_in = pre_start_ff;
      alm_run_in   = alm_run_ff;
      alm_start_in = alm_start_ff;
      ev           = EV_NONE;
      door         = 1'b0;
      if (is_sample) begin
         pre_run_in   = pre_run_tr;
         pre_start_in = pre_start_tr;
         alm_run_in   = alm_run_tr;
         alm_start_in = alm_start_tr;
         case (mode_ff)
            MODE_NORMAL: begin
               if (alm_hit) begin
                  mode_in = MODE_ALARM;
                  ev      = EV_ALARM;
                  door    = 1'b1;
               end else if (pre_hit) begin
                  mode_in = MODE_PRE;
                  ev      = EV_PRE;
               end
            end
            MODE_PRE: begin
               if (alm_hit) begin
                  mode_in = MODE_ALARM;
                  ev      = EV_ALARM;
                  door    = 1'b1;
               end else if (!pre_above) begin
                  mode_in = MODE_NORMAL;
                  ev      = EV_NORMAL;
               end
            end
            default: ;
         endcase
      end else if (mode_ff == MODE_ALARM) begin
         mode_in      = MODE_NORMAL;
         pre_run_in   = 1'b0;
         pre_start_in = '0;
         alm_run_in   = 1'b0;
         alm_start_in = '0;
         ev           = EV_BUTTON;
      end
   end

   // outputs
   always_comb begin
      rsp_data_in.mode               = mode_in;
      rsp_data_in.event_res          = ev;
      rsp_data_in.alarm_light        = (mode_in == MODE_ALARM);
      rsp_data_in.close_door         = door;
      rsp_data_in.reset_enabled      = (mode_in == MODE_ALARM);
      rsp_data_in.temperature_report = is_sample ? in_item_ff.temperature : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         pre_run_ff   <= 1'b0;
         pre_start_ff <= '0;
         alm_run_ff   <= 1'b0;
         alm_start_ff <= '0;
         pre_thr_ff   <= PRE_THR_RESET;
         alm_thr_ff   <= ALM_THR_RESET;
         pre_dwell_ff <= PRE_DWELL_RESET;
         alm_dwell_ff <= ALM_DWELL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff      <= mode_in;
            pre_run_ff   <= pre_run_in;
            pre_start_ff <= pre_start_in;
            alm_run_ff   <= alm_run_in;
            alm_start_ff <= alm_start_in;
         end
         if (csr_write) begin
            case (csr_idx)
               REG_PRE_THR:   pre_thr_ff   <= pwdata[TEMP_BITS-1:0];
               REG_ALM_THR:   alm_thr_ff   <= pwdata[TEMP_BITS-1:0];
               REG_PRE_DWELL: pre_dwell_ff <= pwdata[DWELL_BITS-1:0];
               REG_ALM_DWELL: alm_dwell_ff <= pwdata[DWELL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/dtta_checker.sv
`default_nettype none
`include "dual_threshold_thermal_alarm_core_defines.svh"
module dtta_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input dtta_pkg::rsp_type                    rsp_data
);
   import dtta_pkg::*;

   `DTTA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled item changed")
   `DTTA_ASSERT(a_empty_takes, !rsp_valid |-> !req_stall, "input stalled with empty output")
   `DTTA_ASSERT(a_door_alarm, rsp_valid && rsp_data.close_door |-> rsp_data.event_res == EV_ALARM && rsp_data.alarm_light && rsp_data.reset_enabled, "door pulse without alarm entry")
   `DTTA_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind dual_threshold_thermal_alarm_core dtta_checker u_dtta_checker (.*);
`default_nettype wire
